@@ design/color_distance_soft_key_unit_macros.svh @@
// assertion helpers for the rtl
`ifndef COLOR_DISTANCE_SOFT_KEY_UNIT_MACROS_SVH
`define COLOR_DISTANCE_SOFT_KEY_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define CDSK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cdsk same-cycle check failed");

// next-cycle implication, quiet during reset
`define CDSK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cdsk next-cycle check failed");

`endif

@@ design/cdsk_pkg.sv @@
`default_nettype none

package cdsk_pkg;

    localparam int FRACTION_BITS = 4;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;
    localparam int DIST_W  = 14;   // sum of three 12-bit distances, also 3 * limit
    localparam int LUMA_W  = 11;   // 2r + 3g + b
    localparam int NUM_W   = 25;   // luma * margin
    localparam int QUO_W   = 8;
    localparam int LIM18_W = 17;   // 18 * limit
    localparam int DVS_W   = LIM18_W + QUO_W - 1;
    localparam int DIV_CELLS = QUO_W;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TARGET_RED   = 2'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_GREEN = 2'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_BLUE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_DIST_LIMIT   = 2'd3;

    // reset values
    localparam logic [CFG_W-1:0] RST_TARGET_RED   = 12'd3200;
    localparam logic [CFG_W-1:0] RST_TARGET_GREEN = 12'd3488;
    localparam logic [CFG_W-1:0] RST_TARGET_BLUE  = 12'd2832;
    localparam logic [CFG_W-1:0] RST_DIST_LIMIT   = 12'd912;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             end_of_frame;
    } cdsk_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             frame_done;
    } cdsk_out_t;

    typedef struct packed {
        logic [DIST_W-1:0] gap_sum;
        logic [LUMA_W-1:0] luma;
        logic              eof;
    } cdsk_dist_t;

    typedef struct packed {
        logic [DIST_W-1:0] margin;
        logic [LUMA_W-1:0] luma;
        logic              keyed;
        logic              eof;
    } cdsk_key_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        logic             keyed;
        logic             eof;
    } cdsk_div_t;

endpackage

`default_nettype wire

@@ design/cdsk_dist_cell.sv @@
`default_nettype none

module cdsk_dist_cell
    import cdsk_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CFG_W-1:0] target_red,
    input  wire logic [CFG_W-1:0] target_green,
    input  wire logic [CFG_W-1:0] target_blue,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cdsk_in_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cdsk_dist_t            out_data
);

    logic       valid_reg;
    cdsk_dist_t data_reg;
    cdsk_dist_t data_next;

    logic [CFG_W-1:0] red_fx;
    logic [CFG_W-1:0] green_fx;
    logic [CFG_W-1:0] blue_fx;
    logic [CFG_W-1:0] diff_r;
    logic [CFG_W-1:0] diff_g;
    logic [CFG_W-1:0] diff_b;

    // pixel components in target units
    assign red_fx   = CFG_W'({in_data.red,   {FRACTION_BITS{1'b0}}});
    assign green_fx = CFG_W'({in_data.green, {FRACTION_BITS{1'b0}}});
    assign blue_fx  = CFG_W'({in_data.blue,  {FRACTION_BITS{1'b0}}});

    assign diff_r = (red_fx   >= target_red)   ? red_fx   - target_red
                                               : target_red   - red_fx;
    assign diff_g = (green_fx >= target_green) ? green_fx - target_green
                                               : target_green - green_fx;
    assign diff_b = (blue_fx  >= target_blue)  ? blue_fx  - target_blue
                                               : target_blue  - blue_fx;

    always_comb begin
        data_next.gap_sum = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
        data_next.luma = LUMA_W'({in_data.red, 1'b0}) + LUMA_W'({in_data.green, 1'b0})
                       + LUMA_W'(in_data.green) + LUMA_W'(in_data.blue);
        data_next.eof  = in_data.end_of_frame;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ design/cdsk_key_cell.sv @@
`default_nettype none

module cdsk_key_cell
    import cdsk_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CFG_W-1:0] dist_limit,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cdsk_dist_t       in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cdsk_key_t             out_data
);

    logic      valid_reg;
    cdsk_key_t data_reg;
    cdsk_key_t data_next;

    logic [DIST_W-1:0] limit_x3;

    // mean below limit is the same as sum below three times the limit
    assign limit_x3 = DIST_W'({dist_limit, 1'b0}) + DIST_W'(dist_limit);

    always_comb begin
        data_next.keyed  = in_data.gap_sum < limit_x3;
        data_next.margin = limit_x3 - in_data.gap_sum;
        data_next.luma   = in_data.luma;
        data_next.eof    = in_data.eof;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ design/cdsk_scale_cell.sv @@
`default_nettype none

module cdsk_scale_cell
    import cdsk_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CFG_W-1:0] dist_limit,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cdsk_key_t        in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cdsk_div_t             out_data
);

    logic      valid_reg;
    cdsk_div_t data_reg;
    cdsk_div_t data_next;

    logic [NUM_W-1:0]   product;
    logic [LIM18_W-1:0] limit_x18;

    assign product   = NUM_W'(in_data.luma) * NUM_W'(in_data.margin);
    assign limit_x18 = LIM18_W'({dist_limit, 4'b0000}) + LIM18_W'({dist_limit, 1'b0});

    // divisor is pre-aligned to the top quotient bit
    always_comb begin
        data_next.rem   = in_data.keyed ? product : '0;
        data_next.dvs   = {limit_x18, {(QUO_W-1){1'b0}}};
        data_next.quo   = '0;
        data_next.keyed = in_data.keyed;
        data_next.eof   = in_data.eof;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ design/cdsk_div_cell.sv @@
`default_nettype none

module cdsk_div_cell
    import cdsk_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire cdsk_div_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output cdsk_div_t      out_data
);

    logic      valid_reg;
    cdsk_div_t data_reg;
    cdsk_div_t data_next;

    logic             fits;
    logic [NUM_W-1:0] rem_sub;

    // one restoring step: compare, subtract, shift
    assign fits    = in_data.rem >= NUM_W'(in_data.dvs);
    assign rem_sub = fits ? in_data.rem - NUM_W'(in_data.dvs) : in_data.rem;

    always_comb begin
        data_next.rem   = {rem_sub[NUM_W-2:0], 1'b0};
        data_next.dvs   = in_data.dvs;
        data_next.quo   = {in_data.quo[QUO_W-2:0], fits};
        data_next.keyed = in_data.keyed;
        data_next.eof   = in_data.eof;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ design/color_distance_soft_key_unit.sv @@
// soft color key: one rgb pixel in, one gray pixel out, one item per clock sustained
// while the output is not stalled. one cell forms the summed color distance and
// the luma, one compares against three times the limit, one multiplies luma by
// the remaining margin, and eight identical divider cells each settle one
// quotient bit of the division by 18 * limit. every cell holds a full item and
// hands it to its neighbor, so up to 11 items are in flight; each cell accepts
// whenever it is empty or its neighbor takes its item, so bubbles close up while
// the output waits. targets and limit are unsigned 8.4 fixed point; a zero limit
// or a distance at or above the limit gives gray 0.
// write the configuration registers only while no item is in flight.
`default_nettype none

`include "color_distance_soft_key_unit_macros.svh"

module color_distance_soft_key_unit
    import cdsk_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration write port
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    // pixel input
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cdsk_in_t         s_data,
    // gray output
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cdsk_out_t             m_data
);

    // configuration registers
    logic [CFG_W-1:0] target_red_reg;
    logic [CFG_W-1:0] target_green_reg;
    logic [CFG_W-1:0] target_blue_reg;
    logic [CFG_W-1:0] dist_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_red_reg   <= RST_TARGET_RED;
            target_green_reg <= RST_TARGET_GREEN;
            target_blue_reg  <= RST_TARGET_BLUE;
            dist_limit_reg   <= RST_DIST_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET_RED:   target_red_reg   <= cfg_wr_data;
                REG_TARGET_GREEN: target_green_reg <= cfg_wr_data;
                REG_TARGET_BLUE:  target_blue_reg  <= cfg_wr_data;
                REG_DIST_LIMIT:   dist_limit_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // front cells
    logic       dist_valid;
    logic       dist_ready;
    cdsk_dist_t dist_data;
    logic       key_valid;
    logic       key_ready;
    cdsk_key_t  key_data;

    // divider chain links, link 0 is the scale cell output
    logic [DIV_CELLS:0] div_valid;
    logic [DIV_CELLS:0] div_ready;
    cdsk_div_t          div_data [DIV_CELLS+1];

    cdsk_dist_cell u_dist (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .target_red   (target_red_reg),
        .target_green (target_green_reg),
        .target_blue  (target_blue_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_data      (s_data),
        .out_valid    (dist_valid),
        .out_ready    (dist_ready),
        .out_data     (dist_data)
    );

    cdsk_key_cell u_key (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dist_limit (dist_limit_reg),
        .in_valid   (dist_valid),
        .in_ready   (dist_ready),
        .in_data    (dist_data),
        .out_valid  (key_valid),
        .out_ready  (key_ready),
        .out_data   (key_data)
    );

    cdsk_scale_cell u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dist_limit (dist_limit_reg),
        .in_valid   (key_valid),
        .in_ready   (key_ready),
        .in_data    (key_data),
        .out_valid  (div_valid[0]),
        .out_ready  (div_ready[0]),
        .out_data   (div_data[0])
    );

    // one quotient bit per cell, msb first
    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        cdsk_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // last divider cell is the output register
    assign m_valid             = div_valid[DIV_CELLS];
    assign div_ready[DIV_CELLS] = m_ready;
    assign m_data.gray         = div_data[DIV_CELLS].keyed ? div_data[DIV_CELLS].quo : '0;
    assign m_data.frame_done   = div_data[DIV_CELLS].eof;

    // an accepted pixel always lands in the first cell
    `CDSK_ASSERT_NEXT(a_accept_lands, s_valid && s_ready, dist_valid)
    // a zero limit never keys a pixel
    `CDSK_ASSERT_NOW(a_zero_limit_unkeyed, key_valid && dist_limit_reg == '0, !key_data.keyed)
    // keyed items carry a nonzero divisor into the chain
    `CDSK_ASSERT_NOW(a_divisor_nonzero, div_valid[0] && div_data[0].keyed, div_data[0].dvs != '0)
    // remainder stays below twice the aligned divisor, so the quotient fits
    `CDSK_ASSERT_NOW(a_rem_bound, div_valid[0] && div_data[0].keyed,
        div_data[0].rem < {div_data[0].dvs, 1'b0})

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
    import cdsk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_SETTING = 212;
    localparam int NUM_SETTINGS      = 8;
    localparam int DRAIN_CYCLES      = 24;   // idle clocks before the end of the run

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    cdsk_in_t         s_data;
    logic             m_valid;
    logic             m_ready;
    cdsk_out_t        m_data;

    // local copy of the key registers, follows every write
    logic [CFG_W-1:0] key_red;
    logic [CFG_W-1:0] key_green;
    logic [CFG_W-1:0] key_blue;
    logic [CFG_W-1:0] key_limit;

    cdsk_in_t  pixels_pending[$];   // items waiting for the driver
    cdsk_out_t gray_expected[$];    // expected results owed by the block

    int send_idle_pct;
    int recv_idle_pct;
    int key_errors;

    color_distance_soft_key_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // absolute difference of a pixel component, lifted to 8.4, from a target
    function automatic int color_gap(input logic [PIX_W-1:0] comp, input logic [CFG_W-1:0] tgt);
        int lifted;
        lifted = int'(comp) << FRACTION_BITS;
        return (lifted > int'(tgt)) ? lifted - int'(tgt) : int'(tgt) - lifted;
    endfunction

    // soft key of one pixel against the current target and limit
    function automatic cdsk_out_t key_pixel(input cdsk_in_t px);
        cdsk_out_t res;
        int gap_sum;
        int luma;
        int lim;
        int gray;
        gap_sum = color_gap(px.red, key_red) + color_gap(px.green, key_green)
                + color_gap(px.blue, key_blue);
        lim  = int'(key_limit);
        gray = 0;
        // zero limit never keys; distance at or above the limit gives black
        if (lim != 0 && gap_sum < 3 * lim) begin
            luma = 2 * int'(px.red) + 3 * int'(px.green) + int'(px.blue);
            gray = (luma * (3 * lim - gap_sum)) / (18 * lim);
            if (gray > 255) begin
                gray = 255;
            end
        end
        res.gray       = gray[PIX_W-1:0];
        res.frame_done = px.end_of_frame;
        return res;
    endfunction

    // driver: offers the next pending item, valid held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // predict on acceptance, registers are stable while items fly
            if (s_valid && s_ready) begin
                gray_expected.push_back(key_pixel(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pixels_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pixels_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, each accepted item checked against the oldest prediction
    always @(posedge aclk) begin
        cdsk_out_t want;
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (gray_expected.size() == 0) begin
                $display("%0t: unexpected item gray=%0d frame_done=%0b",
                         $time, m_data.gray, m_data.frame_done);
                key_errors++;
            end else begin
                want = gray_expected.pop_front();
                if (m_data.gray !== want.gray) begin
                    $display("%0t: gray mismatch expected %0d actual %0d",
                             $time, want.gray, m_data.gray);
                    key_errors++;
                end
                if (m_data.frame_done !== want.frame_done) begin
                    $display("%0t: frame_done mismatch expected %0b actual %0b",
                             $time, want.frame_done, m_data.frame_done);
                    key_errors++;
                end
            end
        end
    end

    task automatic add_pixel(input int r, input int g, input int b, input bit eof);
        cdsk_in_t px;
        px.red          = r[PIX_W-1:0];
        px.green        = g[PIX_W-1:0];
        px.blue         = b[PIX_W-1:0];
        px.end_of_frame = eof;
        pixels_pending.push_back(px);
    endtask

    // component close to a target, so that many pixels land inside the limit
    function automatic int near_comp(input logic [CFG_W-1:0] tgt, input int spread);
        int v;
        v = int'(tgt >> FRACTION_BITS) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v;
    endfunction

    task automatic add_random_pixel();
        int spread;
        bit eof;
        eof = ($urandom_range(15) == 0);
        if ($urandom_range(99) < 60) begin
            spread = int'(key_limit >> FRACTION_BITS) + 2;
            if (spread > 255) begin
                spread = 255;
            end
            add_pixel(near_comp(key_red, spread), near_comp(key_green, spread),
                      near_comp(key_blue, spread), eof);
        end else begin
            add_pixel(int'($urandom_range(255)), int'($urandom_range(255)),
                      int'($urandom_range(255)), eof);
        end
    endtask

    // sampled on the falling edge so the driver's queue updates have settled
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pixels_pending.size() != 0 || s_valid || gray_expected.size() != 0);
    endtask

    // only called with nothing in flight; every item gives a result, so no extra wait
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_TARGET_RED:   key_red   = val;
            REG_TARGET_GREEN: key_green = val;
            REG_TARGET_BLUE:  key_blue  = val;
            REG_DIST_LIMIT:   key_limit = val;
            default: ;
        endcase
    endtask

    task automatic write_key(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] g,
                             input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] lim);
        write_reg(REG_TARGET_RED, r);
        write_reg(REG_TARGET_GREEN, g);
        write_reg(REG_TARGET_BLUE, b);
        write_reg(REG_DIST_LIMIT, lim);
    endtask

    initial begin
        int p;
        int n;
        logic [CFG_W-1:0] lim;
        logic [CFG_W-1:0] tr;
        logic [CFG_W-1:0] tg;
        logic [CFG_W-1:0] tb_;

        // configuration port and reset known from time zero
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_TARGET_RED;
        cfg_wr_data   = '0;
        key_red       = RST_TARGET_RED;
        key_green     = RST_TARGET_GREEN;
        key_blue      = RST_TARGET_BLUE;
        key_limit     = RST_DIST_LIMIT;
        key_errors    = 0;
        send_idle_pct = 34;
        recv_idle_pct = 59;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset key: exact target color, then field extremes and bit patterns
        add_pixel(200, 218, 177, 1'b0);
        add_pixel(0, 0, 0, 1'b1);
        add_pixel(255, 255, 255, 1'b0);
        add_pixel(255, 0, 255, 1'b1);
        add_pixel(0, 255, 0, 1'b0);
        add_pixel(170, 85, 170, 1'b1);
        wait_drained();

        // limit of 1.0 around gray 100: inside, and exactly at the limit
        write_key(12'd1600, 12'd1600, 12'd1600, 12'd16);
        add_pixel(100, 100, 100, 1'b0);
        add_pixel(101, 100, 100, 1'b1);
        add_pixel(101, 101, 100, 1'b0);
        add_pixel(101, 101, 101, 1'b1);
        add_pixel(102, 101, 101, 1'b0);
        add_pixel(99, 100, 101, 1'b1);
        wait_drained();

        // zero limit keys nothing, even at the target
        write_reg(REG_DIST_LIMIT, 12'd0);
        add_pixel(100, 100, 100, 1'b1);
        add_pixel(0, 0, 0, 1'b0);
        wait_drained();

        // targets past 255.0 with the widest limit
        write_key(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        add_pixel(255, 255, 255, 1'b1);
        add_pixel(0, 0, 0, 1'b0);
        add_pixel(128, 64, 32, 1'b1);
        wait_drained();

        // smallest nonzero limit at black
        write_key(12'd0, 12'd0, 12'd0, 12'd1);
        add_pixel(0, 0, 0, 1'b0);
        add_pixel(1, 0, 0, 1'b1);
        wait_drained();

        // random items over several key settings, idling pattern changes as we go
        for (p = 0; p < NUM_SETTINGS; p++) begin
            if (p < 3) begin
                send_idle_pct = 34;
                recv_idle_pct = 59;
            end else if (p < 6) begin
                send_idle_pct = 59;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            tr  = CFG_W'($urandom_range(4095));
            tg  = CFG_W'($urandom_range(4095));
            tb_ = CFG_W'($urandom_range(4095));
            case (p)
                1:       lim = 12'hFFF;
                2:       lim = CFG_W'($urandom_range(1, 64));
                3:       lim = 12'd0;
                4:       lim = CFG_W'($urandom_range(1024, 4095));
                5:       lim = 12'd1;
                default: lim = CFG_W'($urandom_range(64, 1024));
            endcase
            if (p == 1) begin
                tr  = 12'hFFF;
                tg  = 12'hFFF;
                tb_ = 12'hFFF;
            end else if (p == 5) begin
                tr  = 12'd0;
                tg  = 12'd0;
                tb_ = 12'd0;
            end
            write_key(tr, tg, tb_, lim);
            for (n = 0; n < ITEMS_PER_SETTING; n++) begin
                // sender holds off mid-setting until the pipeline is empty
                if (n == ITEMS_PER_SETTING / 2) begin
                    wait_drained();
                end
                add_random_pixel();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (key_errors == 0) begin
            $display("color_distance_soft_key_unit verification clean");
        end else begin
            $display("color_distance_soft_key_unit verification failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("color_distance_soft_key_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/cdsk_pkg.sv
design/cdsk_dist_cell.sv
design/cdsk_key_cell.sv
design/cdsk_scale_cell.sv
design/cdsk_div_cell.sv
design/color_distance_soft_key_unit.sv
tb/tb.sv
